// File: hw/rtl/uenc_pkg.sv
// shared types, constants and helpers for the url percent encoder
`timescale 1ns / 1ps

package uenc_pkg;

  localparam int FIFO_DEPTH_DEF = 4;
  localparam int STEP_W = 3;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_TWO     = 8'h32;
  localparam logic [7:0] CHAR_FIVE    = 8'h35;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;

  localparam logic [STEP_W-1:0] STEP_LAST_PLAIN = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LAST_ESC   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LAST_ESC2  = 3'd4;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_ESC   = 2'd1,
    KIND_ESC2  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] w;
    w = {4'd0, v};
    if (v < 4'd10) begin
      hex_digit = CHAR_ZERO + w;
    end else begin
      hex_digit = CHAR_UPPER_A + (w - 8'd10);
    end
  endfunction

endpackage

// File: hw/rtl/uenc_classify.sv
// front end: sorts each input byte into pass-through, escape or double escape
`timescale 1ns / 1ps

module uenc_classify import uenc_pkg::*; (
  input  logic [7:0] in_byte,
  input  logic       double_escape,
  output token_t     token
);

  logic is_plain;
  logic is_control;

  always_comb begin
    is_plain = 1'b0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) is_plain = 1'b1;
    if (in_byte >= 8'h61 && in_byte <= 8'h7A) is_plain = 1'b1;
    if (in_byte >= 8'h41 && in_byte <= 8'h5A) is_plain = 1'b1;
    unique case (in_byte)
      8'h2F, 8'h2E, 8'h28, 8'h29, 8'h21,
      8'h2A, 8'h7E, 8'h5F, 8'h2D, 8'h27: is_plain = 1'b1;
      default: ;
    endcase
  end

  assign is_control = (in_byte <= 8'h1F) || (in_byte == 8'h7F);

  always_comb begin
    token.data = in_byte;
    priority if (is_plain) begin
      token.kind = KIND_PLAIN;
    end else if (double_escape && is_control) begin
      token.kind = KIND_ESC2;
    end else begin
      token.kind = KIND_ESC;
    end
  end

endmodule

// File: hw/rtl/uenc_fifo.sv
// token queue between the classifier and the emitter
`timescale 1ns / 1ps

module uenc_fifo import uenc_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  token_t     wr_token,
  input  logic       rd_en,
  output token_t     rd_token,
  output fifo_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

  token_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign stat.full  = (count == CNT_MAX);
  assign stat.empty = (count == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_token   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_MAX) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_MAX) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/uenc_emit.sv
// back end: steps through tokens, registers a byte per cycle unless stalled
`timescale 1ns / 1ps

module uenc_emit import uenc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  token_t     head,
  input  fifo_stat_t fifo_stat,
  output logic       head_pop,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       run_last
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic [STEP_W-1:0] last_step;
  logic [7:0]        char_sel;
  logic              out_valid;
  logic              advance;
  logic              is_last;

  assign advance  = (!out_valid || pop) && !fifo_stat.empty;
  assign is_last  = (step == last_step);
  assign head_pop = advance && is_last;
  assign empty    = !out_valid;

  always_comb begin
    last_step = STEP_LAST_PLAIN;
    char_sel  = head.data;
    unique case (head.kind)
      KIND_PLAIN: begin
        last_step = STEP_LAST_PLAIN;
        char_sel  = head.data;
      end
      KIND_ESC: begin
        last_step = STEP_LAST_ESC;
        unique case (step)
          3'd0:    char_sel = CHAR_PERCENT;
          3'd1:    char_sel = hex_digit(head.data[7:4]);
          default: char_sel = hex_digit(head.data[3:0]);
        endcase
      end
      KIND_ESC2: begin
        last_step = STEP_LAST_ESC2;
        unique case (step)
          3'd0:    char_sel = CHAR_PERCENT;
          3'd1:    char_sel = CHAR_TWO;
          3'd2:    char_sel = CHAR_FIVE;
          3'd3:    char_sel = hex_digit(head.data[7:4]);
          default: char_sel = hex_digit(head.data[3:0]);
        endcase
      end
      default: begin
        last_step = STEP_LAST_PLAIN;
        char_sel  = head.data;
      end
    endcase
  end

  always_comb begin
    step_next = step;
    if (advance) begin
      step_next = is_last ? '0 : step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= char_sel;
      run_last <= is_last;
    end
  end

endmodule

// File: hw/rtl/url_percent_encoder.sv
// Top level of the url percent encoder: classifier, token queue, emitter.
// A taken byte goes through the token queue and then the output register.
// Throughput: one output byte per cycle from the step counter unless stalled,
// so a byte gives 1, 3 or 5 output bytes (pass-through, escape, double escape).
// Input and output stall independently through the token queue.
// Reset empties the queue and output register and sets double escaping to 1.
`timescale 1ns / 1ps

module url_percent_encoder import uenc_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       run_last,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic       double_escape;
  token_t     in_token;
  token_t     head;
  fifo_stat_t fifo_stat;
  logic       head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      double_escape <= 1'b1;
    end else if (cfg_we) begin
      double_escape <= cfg_wdata;
    end
  end

  uenc_classify u_classify (
    .in_byte       (in_byte),
    .double_escape (double_escape),
    .token         (in_token)
  );

  uenc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_token (in_token),
    .rd_en    (head_pop),
    .rd_token (head),
    .stat     (fifo_stat)
  );

  uenc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .fifo_stat (fifo_stat),
    .head_pop  (head_pop),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .run_last  (run_last)
  );

  assign full = fifo_stat.full;

  a_queue_flags: assert property (@(posedge clk) disable iff (rst)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("token queue both full and empty");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !run_last) |=> !empty)
    else $error("output run broken before its last byte");

  a_percent_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_char == CHAR_PERCENT) |-> !run_last)
    else $error("percent sign ended a run");

  a_idle_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty && fifo_stat.empty) |-> ##2 !empty)
    else $error("output not shown two cycles after transfer into idle block");

endmodule
